[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the payload locator modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// clocked assertion, disabled while reset is active (reset is active low)
`define L4PL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("l4pl assertion failed");

// clocked assertion, checked during reset too
`define L4PL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("l4pl assertion failed");

`else

`define L4PL_ASSERT(lbl, clk, rst_n, prop)
`define L4PL_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/core/l4pl_pkg.sv]
// ----------------------------------------------------------------------------
// l4pl_pkg
// Types and constants for the layer-4 payload locator.
// ----------------------------------------------------------------------------
package l4pl_pkg;

    // byte positions of captured header fields (position counter is 7 bits)
    localparam logic [6:0] POS_VER_IHL  = 7'd14;
    localparam logic [6:0] POS_TLEN_HI  = 7'd16;
    localparam logic [6:0] POS_TLEN_LO  = 7'd17;
    localparam logic [6:0] POS_FRAG_HI  = 7'd20;
    localparam logic [6:0] POS_FRAG_LO  = 7'd21;
    localparam logic [6:0] POS_PROTO    = 7'd23;
    localparam logic [6:0] POS_TCP_BASE = 7'd26;
    localparam logic [6:0] POS_MAX      = 7'd127;

    localparam logic [7:0]  ETH_HDR_LEN   = 8'd14;
    localparam logic [7:0]  VER_MASK      = 8'hF0;
    localparam logic [7:0]  VER_IPV4      = 8'h40;
    localparam logic [15:0] FRAG_MF       = 16'h2000;
    localparam logic [15:0] FRAG_OFF_MASK = 16'h1FFF;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [5:0]  UDP_HDR_LEN   = 6'd8;

    // bit index into the seen mask
    localparam int SEEN_VER   = 0;
    localparam int SEEN_TLEN  = 1;
    localparam int SEEN_FRAG  = 2;
    localparam int SEEN_PROTO = 3;
    localparam int SEEN_TCPO  = 4;

    typedef enum logic [2:0] {
        ST_PAYLOAD   = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_NOT_IPV4  = 3'd2,
        ST_FRAGMENT  = 3'd3,
        ST_OTHER     = 3'd4,
        ST_TRUNCATED = 3'd5,
        ST_BAD_LEN   = 3'd6
    } t_status;

    typedef struct packed {
        logic [7:0]  ver_ihl;
        logic [15:0] tot_len;
        logic [15:0] frag;
        logic [7:0]  proto;
        logic [7:0]  tcp_off;
        logic [4:0]  seen;
    } t_hdr;

endpackage

[rtl/core/l4pl_capture.sv]
// ----------------------------------------------------------------------------
// l4pl_capture
// Tracks the byte position and captures IPv4/TCP header fields; hands a
// header snapshot to the classifier on the last byte of each frame.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module l4pl_capture (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_frame_byte,
    input  logic             i_last_byte,
    input  logic             i_snap_take,
    output logic             o_snap_valid,
    output l4pl_pkg::t_hdr   o_snap
);

    logic [6:0]      r_pos;
    logic [6:0]      n_pos;
    l4pl_pkg::t_hdr  r_live;
    l4pl_pkg::t_hdr  n_live;
    l4pl_pkg::t_hdr  r_snap;
    logic            r_snap_v;
    logic [6:0]      tcp_pos;
    logic            accept;

    assign o_in_stall   = r_snap_v && !i_snap_take;
    assign accept       = i_in_valid && !o_in_stall;
    assign o_snap_valid = r_snap_v;
    assign o_snap       = r_snap;

    assign tcp_pos = l4pl_pkg::POS_TCP_BASE + {1'b0, r_live.ver_ihl[3:0], 2'b00};

    always_comb begin
        n_live = r_live;
        n_pos  = (r_pos != l4pl_pkg::POS_MAX) ? r_pos + 7'd1 : r_pos;
        case (r_pos)
            l4pl_pkg::POS_VER_IHL: begin
                n_live.ver_ihl = i_frame_byte;
                n_live.seen[l4pl_pkg::SEEN_VER] = 1'b1;
            end
            l4pl_pkg::POS_TLEN_HI: begin
                n_live.tot_len[15:8] = i_frame_byte;
            end
            l4pl_pkg::POS_TLEN_LO: begin
                n_live.tot_len[7:0] = i_frame_byte;
                n_live.seen[l4pl_pkg::SEEN_TLEN] = 1'b1;
            end
            l4pl_pkg::POS_FRAG_HI: begin
                n_live.frag[15:8] = i_frame_byte;
            end
            l4pl_pkg::POS_FRAG_LO: begin
                n_live.frag[7:0] = i_frame_byte;
                n_live.seen[l4pl_pkg::SEEN_FRAG] = 1'b1;
            end
            l4pl_pkg::POS_PROTO: begin
                n_live.proto = i_frame_byte;
                n_live.seen[l4pl_pkg::SEEN_PROTO] = 1'b1;
            end
            default: begin
            end
        endcase
        // tcp data offset position never coincides with the version byte
        if (r_live.seen[l4pl_pkg::SEEN_VER] && (r_pos == tcp_pos)) begin
            n_live.tcp_off = i_frame_byte;
            n_live.seen[l4pl_pkg::SEEN_TCPO] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_live   <= '0;
            r_snap_v <= 1'b0;
        end else begin
            if (accept) begin
                if (i_last_byte) begin
                    r_pos  <= '0;
                    r_live <= '0;
                end else begin
                    r_pos  <= n_pos;
                    r_live <= n_live;
                end
            end
            if (accept && i_last_byte) begin
                r_snap_v <= 1'b1;
            end else if (i_snap_take) begin
                r_snap_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last_byte) begin
            r_snap <= n_live;
        end
    end

    `L4PL_ASSERT(a_snap_hold, i_clk, i_rst_n,
        r_snap_v && !i_snap_take |=> r_snap_v && $stable(r_snap))
    `L4PL_ASSERT(a_frame_clear, i_clk, i_rst_n,
        accept && i_last_byte |=> r_pos == 7'd0 && r_live.seen == 5'd0)
    `L4PL_ASSERT(a_tcpo_after_ver, i_clk, i_rst_n,
        r_live.seen[l4pl_pkg::SEEN_TCPO] |-> r_live.seen[l4pl_pkg::SEEN_VER])

endmodule

[rtl/core/l4pl_classify.sv]
// ----------------------------------------------------------------------------
// l4pl_classify
// Classifies a captured header snapshot and holds the result transaction
// in the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module l4pl_classify (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_snap_valid,
    input  l4pl_pkg::t_hdr   i_snap,
    output logic             o_snap_take,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [7:0]       o_payload_offset,
    output logic [15:0]      o_payload_length
);

    logic                r_out_v;
    l4pl_pkg::t_status   r_status;
    l4pl_pkg::t_status   n_status;
    logic [7:0]          r_offset;
    logic [7:0]          n_offset;
    logic [15:0]         r_length;
    logic [15:0]         n_length;
    logic                load;
    logic                is_tcp;
    logic [5:0]          ip_hlen;
    logic [5:0]          l4_hlen;
    logic [6:0]          need;
    logic [15:0]         pay_len;

    assign load        = !r_out_v || !i_out_stall;
    assign o_snap_take = i_snap_valid && load;

    assign is_tcp  = (i_snap.proto == l4pl_pkg::PROTO_TCP);
    assign ip_hlen = {i_snap.ver_ihl[3:0], 2'b00};
    assign l4_hlen = is_tcp ? {i_snap.tcp_off[7:4], 2'b00} : l4pl_pkg::UDP_HDR_LEN;
    assign need    = {1'b0, ip_hlen} + {1'b0, l4_hlen};
    assign pay_len = i_snap.tot_len - {9'd0, need};

    always_comb begin
        n_status = l4pl_pkg::ST_TRUNCATED;
        n_offset = '0;
        n_length = '0;
        if (!i_snap.seen[l4pl_pkg::SEEN_VER]) begin
            n_status = l4pl_pkg::ST_TRUNCATED;
        end else if ((i_snap.ver_ihl & l4pl_pkg::VER_MASK) != l4pl_pkg::VER_IPV4) begin
            n_status = l4pl_pkg::ST_NOT_IPV4;
        end else if (!i_snap.seen[l4pl_pkg::SEEN_FRAG] || !i_snap.seen[l4pl_pkg::SEEN_TLEN]) begin
            n_status = l4pl_pkg::ST_TRUNCATED;
        end else if ((i_snap.frag & (l4pl_pkg::FRAG_MF | l4pl_pkg::FRAG_OFF_MASK)) != '0) begin
            n_status = l4pl_pkg::ST_FRAGMENT;
        end else if (!i_snap.seen[l4pl_pkg::SEEN_PROTO]) begin
            n_status = l4pl_pkg::ST_TRUNCATED;
        end else if (!is_tcp && (i_snap.proto != l4pl_pkg::PROTO_UDP)) begin
            n_status = l4pl_pkg::ST_OTHER;
        end else if (is_tcp && !i_snap.seen[l4pl_pkg::SEEN_TCPO]) begin
            n_status = l4pl_pkg::ST_TRUNCATED;
        end else if (i_snap.tot_len < {9'd0, need}) begin
            n_status = l4pl_pkg::ST_BAD_LEN;
        end else begin
            n_offset = l4pl_pkg::ETH_HDR_LEN + {1'b0, need};
            if (pay_len == '0) begin
                n_status = l4pl_pkg::ST_EMPTY;
            end else begin
                n_status = l4pl_pkg::ST_PAYLOAD;
                n_length = pay_len;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (load) begin
            r_out_v <= i_snap_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_snap_take) begin
            r_status <= n_status;
            r_offset <= n_offset;
            r_length <= n_length;
        end
    end

    assign o_out_valid      = r_out_v;
    assign o_status         = r_status;
    assign o_payload_offset = r_offset;
    assign o_payload_length = r_length;

    `L4PL_ASSERT(a_payload_nonzero, i_clk, i_rst_n,
        r_out_v && r_status == l4pl_pkg::ST_PAYLOAD |-> r_length != 16'd0)
    `L4PL_ASSERT(a_offset_only_ok, i_clk, i_rst_n,
        r_out_v && r_status != l4pl_pkg::ST_PAYLOAD && r_status != l4pl_pkg::ST_EMPTY
            |-> r_offset == 8'd0 && r_length == 16'd0)

endmodule

[rtl/core/l4_payload_locator.sv]
// ----------------------------------------------------------------------------
// l4_payload_locator: layer-4 payload finder for Ethernet/IPv4 bytes
// Last byte to result: snapshot register, then output register
// Throughput: 1 byte per cycle; input stalls only while a finished frame waits
// behind a stalled result. Sync active-low reset clears capture state, valid flags
// ----------------------------------------------------------------------------
module l4_payload_locator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [7:0]   i_frame_byte,
    input  logic         i_last_byte,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [2:0]   o_status,
    output logic [7:0]   o_payload_offset,
    output logic [15:0]  o_payload_length
);

    logic            snap_valid;
    logic            snap_take;
    l4pl_pkg::t_hdr  snap;

    l4pl_capture u_capture (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .i_snap_take  (snap_take),
        .o_snap_valid (snap_valid),
        .o_snap       (snap)
    );

    l4pl_classify u_classify (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_snap_valid     (snap_valid),
        .i_snap           (snap),
        .o_snap_take      (snap_take),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_payload_offset (o_payload_offset),
        .o_payload_length (o_payload_length)
    );

endmodule
